FILE: rtl/core/euler_zxy_to_quaternion_macros.svh
// Assertion macros for the euler_zxy_to_quaternion block.
// Used by the top level only; no other dependencies.
`ifndef EULER_ZXY_TO_QUATERNION_MACROS_SVH
`define EULER_ZXY_TO_QUATERNION_MACROS_SVH
// implication checked every clock outside reset
`define EZQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define EZQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: rtl/core/ezq_pkg.sv
// Shared constants, types and arithmetic helpers for euler_zxy_to_quaternion.
// No dependencies.
package ezq_pkg;
	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int OUT_FRAC_BITS_DEF = 14;
	localparam int QF                = 30;
	localparam int SERIES_TERMS      = 10;
	// number of series cells, one per series term
	localparam int N_CELLS           = SERIES_TERMS;
	localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
	localparam logic [32:0] PI_Q30      = 33'd3373259426;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

	typedef logic [31:0] q30_t;       // unsigned magnitude, Q.30, below 4.0
	typedef logic signed [31:0] sq30_t;

	// rounded unsigned Q.30 product
	function automatic q30_t mulq(input q30_t p, input q30_t q);
		logic [63:0] pr;
		pr = 64'(p) * 64'(q) + 64'(ONE_Q30 >> 1);
		return pr[61:30];
	endfunction

	// sign-magnitude signed product; values lie within +-2^30
	function automatic sq30_t smul(input sq30_t p, input sq30_t q);
		q30_t up;
		q30_t uq;
		q30_t r;
		up = p[31] ? q30_t'(-p) : q30_t'(p);
		uq = q[31] ? q30_t'(-q) : q30_t'(q);
		r  = mulq(up, uq);
		return (p[31] ^ q[31]) ? -sq30_t'(r) : sq30_t'(r);
	endfunction

	// divisor of series term k (1-based)
	function automatic logic [8:0] sin_div(input int k);
		return 9'((2 * k) * (2 * k + 1));
	endfunction
	function automatic logic [8:0] cos_div(input int k);
		return 9'((2 * k - 1) * (2 * k));
	endfunction

	// reciprocal ceil(2^sh / d), exact floor division of 32-bit values when
	// sh = 32 + clog2(d); evaluated on constants only
	function automatic logic [32:0] recip(input logic [8:0] d, input int sh);
		logic [63:0] num;
		num = (64'd1 << sh) + 64'(d) - 64'd1;
		return 33'(num / 64'(d));
	endfunction

	// sine/cosine lane carried along the cell row
	typedef struct packed {
		q30_t  a2;
		q30_t  st;
		q30_t  ct;
		logic signed [33:0] ssum;
		logic signed [33:0] csum;
		logic  sneg;
		logic  cneg;
	} lane_t;
endpackage

FILE: rtl/core/ezq_fold.sv
// Half angle and quadrant fold for one angle, then a2 = a*a.
// Depends on ezq_pkg. One register stage.
module ezq_fold #(
	parameter int ANGLE_WIDTH = ezq_pkg::ANGLE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [ANGLE_WIDTH-1:0] angle,
	output ezq_pkg::lane_t         lane
);
	localparam int SH = 29 - (ANGLE_WIDTH - 4);
	logic signed [63:0] h;
	logic [63:0] a0;
	logic [63:0] a1;
	logic sneg;
	logic cneg;

	always_comb begin
		h    = 64'(signed'(angle)) <<< SH;
		sneg = h[63];
		a0   = sneg ? 64'(-h) : 64'(h);
		cneg = 1'b0;
		a1   = a0;
		if (a0 > 64'(ezq_pkg::HALF_PI_Q30)) begin
			a1   = 64'(ezq_pkg::PI_Q30) - a0;
			cneg = 1'b1;
		end
		if (a1[63]) begin
			a1   = -a1;
			sneg = !sneg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane.a2   <= ezq_pkg::mulq(a1[31:0], a1[31:0]);
			lane.st   <= a1[31:0];
			lane.ct   <= ezq_pkg::ONE_Q30;
			lane.ssum <= 34'(a1[31:0]);
			lane.csum <= 34'(ezq_pkg::ONE_Q30);
			lane.sneg <= sneg;
			lane.cneg <= cneg;
		end
	end
endmodule

FILE: rtl/core/ezq_cell.sv
// One series cell: advances sine and cosine terms by one step.
// Depends on ezq_pkg. Two register stages (product, then divide/accumulate).
module ezq_cell #(
	parameter int K = 1
) (
	input  logic           clk,
	input  logic           en,
	input  ezq_pkg::lane_t lane_in,
	output ezq_pkg::lane_t lane_out
);
	localparam logic [8:0] SD = ezq_pkg::sin_div(K);
	localparam logic [8:0] CD = ezq_pkg::cos_div(K);
	// floor(x / d) as (x * m) >> (32 + clog2(d)), exact for 32-bit x
	localparam int SSH = 32 + $clog2(SD);
	localparam int CSH = 32 + $clog2(CD);
	localparam logic [32:0] SM = ezq_pkg::recip(SD, SSH);
	localparam logic [32:0] CM = ezq_pkg::recip(CD, CSH);
	ezq_pkg::lane_t l_s1;
	ezq_pkg::lane_t nxt;
	ezq_pkg::q30_t sp_s1, cp_s1;
	ezq_pkg::q30_t sq, cq;
	logic [64:0] sprod, cprod;

	always_ff @(posedge clk) begin
		if (en) begin
			l_s1  <= lane_in;
			sp_s1 <= ezq_pkg::mulq(lane_in.st, lane_in.a2);
			cp_s1 <= ezq_pkg::mulq(lane_in.ct, lane_in.a2);
		end
	end

	// division by a small constant through its reciprocal
	assign sprod = 65'(sp_s1) * 65'(SM);
	assign cprod = 65'(cp_s1) * 65'(CM);
	assign sq    = 32'(sprod >> SSH);
	assign cq    = 32'(cprod >> CSH);

	always_comb begin
		nxt    = l_s1;
		nxt.st = sq;
		nxt.ct = cq;
		if (K % 2 == 1) begin
			nxt.ssum = l_s1.ssum - 34'(sq);
			nxt.csum = l_s1.csum - 34'(cq);
		end else begin
			nxt.ssum = l_s1.ssum + 34'(sq);
			nxt.csum = l_s1.csum + 34'(cq);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_out <= nxt;
		end
	end
endmodule

FILE: rtl/core/ezq_combine.sv
// Quaternion combine: clamps series sums, forms three-term products, rounds.
// Depends on ezq_pkg. Three register stages.
module ezq_combine #(
	parameter int OUT_FRAC_BITS = ezq_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  ezq_pkg::lane_t               lx,
	input  ezq_pkg::lane_t               ly,
	input  ezq_pkg::lane_t               lz,
	output logic signed [OUT_FRAC_BITS+1:0] qx,
	output logic signed [OUT_FRAC_BITS+1:0] qy,
	output logic signed [OUT_FRAC_BITS+1:0] qz,
	output logic signed [OUT_FRAC_BITS+1:0] qw
);
	localparam int SH = ezq_pkg::QF - OUT_FRAC_BITS;
	typedef logic signed [OUT_FRAC_BITS+1:0] out_t;
	ezq_pkg::sq30_t sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	ezq_pkg::sq30_t p_s2 [8];
	ezq_pkg::sq30_t sx_s2, sy_s2, sz_s2, cz_s2;

	function automatic ezq_pkg::sq30_t fin(input logic signed [33:0] v, input logic ng);
		logic signed [33:0] c;
		c = v;
		if (v > 34'sd1073741824) c = 34'sd1073741824;
		if (v < -34'sd1073741824) c = -34'sd1073741824;
		return ng ? -ezq_pkg::sq30_t'(c) : ezq_pkg::sq30_t'(c);
	endfunction

	function automatic out_t to_out(input logic signed [33:0] v);
		logic [33:0] mag;
		logic [33:0] r;
		mag = v[33] ? 34'(-v) : 34'(v);
		if (SH > 0)
			r = (mag + (34'd1 << (SH - 1))) >> SH;
		else
			r = mag;
		if (r > (34'd1 << OUT_FRAC_BITS)) r = 34'd1 << OUT_FRAC_BITS;
		return v[33] ? out_t'(-r) : out_t'(r);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= fin(lx.ssum, lx.sneg); cx_s1 <= fin(lx.csum, lx.cneg);
			sy_s1 <= fin(ly.ssum, ly.sneg); cy_s1 <= fin(ly.csum, ly.cneg);
			sz_s1 <= fin(lz.ssum, lz.sneg); cz_s1 <= fin(lz.csum, lz.cneg);
		end
	end

	// first pair products
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= ezq_pkg::smul(cy_s1, cz_s1);
			p_s2[1] <= ezq_pkg::smul(cx_s1, sy_s1);
			p_s2[2] <= ezq_pkg::smul(cx_s1, cz_s1);
			p_s2[3] <= ezq_pkg::smul(cy_s1, sx_s1);
			p_s2[4] <= ezq_pkg::smul(cx_s1, cy_s1);
			p_s2[5] <= ezq_pkg::smul(cz_s1, sx_s1);
			p_s2[6] <= ezq_pkg::smul(cx_s1, cy_s1);
			p_s2[7] <= ezq_pkg::smul(sx_s1, sy_s1);
			sx_s2 <= sx_s1; sy_s2 <= sy_s1; sz_s2 <= sz_s1; cz_s2 <= cz_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx <= to_out(34'(ezq_pkg::smul(p_s2[0], sx_s2)) - 34'(ezq_pkg::smul(p_s2[1], sz_s2)));
			qy <= to_out(34'(ezq_pkg::smul(p_s2[2], sy_s2)) + 34'(ezq_pkg::smul(p_s2[3], sz_s2)));
			qz <= to_out(34'(ezq_pkg::smul(p_s2[4], sz_s2)) + 34'(ezq_pkg::smul(p_s2[5], sy_s2)));
			qw <= to_out(34'(ezq_pkg::smul(p_s2[6], cz_s2)) - 34'(ezq_pkg::smul(p_s2[7], sz_s2)));
		end
	end
endmodule

FILE: rtl/core/euler_zxy_to_quaternion.sv
// ZXY Euler angles to quaternion, top level.
// Channels: in_valid/in_ready carry one request of pitch, yaw and roll
// angles (signed, ANGLE_WIDTH bits, ANGLE_WIDTH-4 fraction bits).
// out_valid/out_ready carry quat_x/y/z/w, signed Q1.OUT_FRAC_BITS, clamped
// to +-1.0. One result per request, in request order.
// Each angle runs through one fold register, then a row of ten series cells
// (two stages each, one Taylor term of sine and cosine per cell), then a
// three-stage combine and the output register: LAT = 25 register slots in
// all, tracked by the valid shift line whose last slot drives out_valid.
// Throughput: one request per cycle unless stalled. The whole row advances
// together: it moves whenever the output register is empty or being drained,
// so a stalled receiver freezes the row and in_ready drops in the same cycle.
// Reset clears only the valid shift line; data registers are not reset.
// Depends on ezq_pkg, ezq_fold, ezq_cell, ezq_combine and the macros header.
`include "euler_zxy_to_quaternion_macros.svh"
module euler_zxy_to_quaternion #(
	parameter int ANGLE_WIDTH   = ezq_pkg::ANGLE_WIDTH_DEF,
	parameter int OUT_FRAC_BITS = ezq_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [ANGLE_WIDTH-1:0]   pitch_angle,
	input  logic signed [ANGLE_WIDTH-1:0]   yaw_angle,
	input  logic signed [ANGLE_WIDTH-1:0]   roll_angle,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [OUT_FRAC_BITS+1:0] quat_x,
	output logic signed [OUT_FRAC_BITS+1:0] quat_y,
	output logic signed [OUT_FRAC_BITS+1:0] quat_z,
	output logic signed [OUT_FRAC_BITS+1:0] quat_w
);
	localparam int NC  = ezq_pkg::N_CELLS;
	localparam int LAT = 1 + 2 * NC + 3 + 1;

	logic en;
	logic [LAT-1:0] vld_q;

	// advance when the last slot is empty or its result is taken
	assign en        = !vld_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// the fold register is covered by the first slot of vld_q
	ezq_pkg::lane_t row_x [NC+1];
	ezq_pkg::lane_t row_y [NC+1];
	ezq_pkg::lane_t row_z [NC+1];

	ezq_fold #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_fx (
		.clk(clk), .en(en), .angle(pitch_angle), .lane(row_x[0]));
	ezq_fold #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_fy (
		.clk(clk), .en(en), .angle(yaw_angle), .lane(row_y[0]));
	ezq_fold #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_fz (
		.clk(clk), .en(en), .angle(roll_angle), .lane(row_z[0]));

	for (genvar k = 0; k < NC; k++) begin : g_row
		ezq_cell #(.K(k + 1)) u_cx (
			.clk(clk), .en(en), .lane_in(row_x[k]), .lane_out(row_x[k+1]));
		ezq_cell #(.K(k + 1)) u_cy (
			.clk(clk), .en(en), .lane_in(row_y[k]), .lane_out(row_y[k+1]));
		ezq_cell #(.K(k + 1)) u_cz (
			.clk(clk), .en(en), .lane_in(row_z[k]), .lane_out(row_z[k+1]));
	end

	logic signed [OUT_FRAC_BITS+1:0] cx_s, cy_s, cz_s, cw_s;
	ezq_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_comb (
		.clk(clk), .en(en), .lx(row_x[NC]), .ly(row_y[NC]), .lz(row_z[NC]),
		.qx(cx_s), .qy(cy_s), .qz(cz_s), .qw(cw_s));

	// output register, the last slot of the valid line
	always_ff @(posedge clk) begin
		if (en) begin
			quat_x <= cx_s;
			quat_y <= cy_s;
			quat_z <= cz_s;
			quat_w <= cw_s;
		end
	end

	localparam logic signed [OUT_FRAC_BITS+1:0] LIM = (OUT_FRAC_BITS+2)'(1) << OUT_FRAC_BITS;

	`EZQ_ASSERT_IMP(a_ready_free, clk, arst_n, !out_valid, in_ready)
	`EZQ_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(quat_w))
	`EZQ_ASSERT_IMP(a_wrange, clk, arst_n, out_valid, quat_w <= LIM && quat_w >= -LIM)
endmodule
